// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Expects clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising clock, off while in reset.
`define FSHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, but also evaluated during reset.
`define FSHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/fshc_pkg.sv
// Package for the fan speed hysteresis classifier: fan table, microcode types,
// configuration register indexes. No dependencies.
package fshc_pkg;

  localparam int unsigned SpeedW   = 13;
  localparam int unsigned WordW    = 15;
  localparam int unsigned ClassOutW = 3;
  localparam int unsigned TableRows = 6;
  localparam int unsigned RowIdxW   = 4;

  localparam logic [SpeedW-1:0] MinSpeedReset = 13'd1800;
  localparam logic [SpeedW-1:0] MaxSpeedReset = 13'd5500;

  // configuration register indexes
  localparam logic CFG_MIN_SPEED = 1'b0;
  localparam logic CFG_MAX_SPEED = 1'b1;

  // microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_RISE  = 3'd1;
  localparam step_t STEP_FALL  = 3'd2;
  localparam step_t STEP_CLAMP = 3'd3;
  localparam step_t STEP_EMIT  = 3'd4;

  typedef enum logic [2:0] {
    OP_WAIT,   // take a word from the input channel
    OP_RISE,   // climb one class if above next row's rise threshold
    OP_FALL,   // drop one class if below this row's fall threshold
    OP_CLAMP,  // look up speed, use the ceiling if outside floor/ceiling, decide emission
    OP_EMIT    // hand the result to the output register
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_RISE_OK,
    COND_FALL_OK,
    COND_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t jmp;   // taken when cond holds
    step_t nxt;   // taken otherwise
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_accept;
    logic rise_ok;
    logic fall_ok;
    logic out_blocked;
  } useq_status_t;

  function automatic logic [RowIdxW-1:0] row_clamp(input logic [RowIdxW-1:0] idx);
    row_clamp = (idx >= RowIdxW'(TableRows)) ? RowIdxW'(TableRows - 1) : idx;
  endfunction

  function automatic logic [SpeedW-1:0] row_rpm(input logic [RowIdxW-1:0] idx);
    unique case (row_clamp(idx))
      4'd0:    row_rpm = 13'd1800;
      4'd1:    row_rpm = 13'd2000;
      4'd2:    row_rpm = 13'd3000;
      4'd3:    row_rpm = 13'd4000;
      4'd4:    row_rpm = 13'd5000;
      default: row_rpm = 13'd5500;
    endcase
  endfunction

  function automatic logic [7:0] row_rise(input logic [RowIdxW-1:0] idx);
    unique case (row_clamp(idx))
      4'd0:    row_rise = 8'd30;
      4'd1:    row_rise = 8'd65;
      4'd2:    row_rise = 8'd70;
      4'd3:    row_rise = 8'd75;
      4'd4:    row_rise = 8'd80;
      default: row_rise = 8'd90;
    endcase
  endfunction

  function automatic logic [7:0] row_fall(input logic [RowIdxW-1:0] idx);
    unique case (row_clamp(idx))
      4'd0:    row_fall = 8'd30;
      4'd1:    row_fall = 8'd55;
      4'd2:    row_fall = 8'd65;
      4'd3:    row_fall = 8'd70;
      4'd4:    row_fall = 8'd70;
      default: row_fall = 8'd80;
    endcase
  endfunction

endpackage

// File: sv/fan_speed_hysteresis_classifier_top.sv
// Top level of the fan speed hysteresis classifier: datapath, configuration
// registers, output register. Depends on fshc_pkg, fshc_useq, assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o): one word per temperature sample,
//   temperature_i plus force_update_i. Output channel (out_valid_o/out_ready_i):
//   at most one result word per sample: speed_rpm_o, speed_word_o (speed x4,
//   13.2 format) and class_index_o. cfg_we_i writes cfg_wdata_i to the floor (index 0) or
//   ceiling (index 1) speed register; the user writes only while the block is idle (not enforced).
// Timing:
//   A microprogram steps a small datapath: wait, climb loop, fall loop, clamp,
//   emit. A sample climbs or falls, never both. A new sample is taken only after
//   the previous one has left the emit step; its result is loaded in that step.
// Reset:
//   Class goes to the top row, last speed to zero (first sample emits while the
//   ceiling is nonzero), floor/ceiling to 1800/5500 rpm, output register empty.
// Stall:
//   A held result does not block the next sample; the emit step waits only
//   if a new result is due while the previous one is still not taken.
module fan_speed_hysteresis_classifier_top
  import fshc_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = 6,
  parameter int unsigned TEMP_BITS   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_addr_i,
  input  logic [SpeedW-1:0]    cfg_wdata_i,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TEMP_BITS-1:0] temperature_i,
  input  logic                 force_update_i,
  // output words
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SpeedW-1:0]    speed_rpm_o,
  output logic [WordW-1:0]     speed_word_o,
  output logic [ClassOutW-1:0] class_index_o
);

`include "assert_macros.svh"

  localparam int unsigned ClsW = $clog2(NUM_CLASSES);
  localparam logic [ClsW-1:0] TopClass = ClsW'(NUM_CLASSES - 1);

  op_e          op;
  useq_status_t status;

  // config registers
  logic [SpeedW-1:0] min_q, max_q;

  // working state
  logic [TEMP_BITS-1:0] temp_q;
  logic                 force_q;
  logic [ClsW-1:0]      cls_q, cls_d;
  logic [SpeedW-1:0]    last_q, last_d;
  logic                 emit_q, emit_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [SpeedW-1:0]    out_speed_q;
  logic [ClassOutW-1:0] out_class_q;

  logic                 in_accept;
  logic                 out_load;
  logic [ClsW-1:0]      cls_up;
  logic [RowIdxW-1:0]   up_idx, cur_idx;
  logic [SpeedW-1:0]    row_speed, speed_sel;

  fshc_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  assign in_ready_o = (op == OP_WAIT);
  assign in_accept  = in_valid_i && in_ready_o;

  // table lookups: next row's rise threshold, current row's fall and speed
  assign cls_up    = cls_q + 1'b1;
  assign up_idx    = RowIdxW'(cls_up);
  assign cur_idx   = RowIdxW'(cls_q);
  assign row_speed = row_rpm(cur_idx);
  assign speed_sel = (row_speed < min_q || row_speed > max_q) ? max_q : row_speed;

  assign status.in_accept   = in_accept;
  assign status.rise_ok     = (cls_q < TopClass) && (temp_q > TEMP_BITS'(row_rise(up_idx)));
  assign status.fall_ok     = (cls_q != '0) && (temp_q < TEMP_BITS'(row_fall(cur_idx)));
  assign status.out_blocked = emit_q && out_valid_q && !out_ready_i;

  assign out_load = (op == OP_EMIT) && emit_q && !status.out_blocked;

  always_comb begin
    cls_d  = cls_q;
    last_d = last_q;
    emit_d = emit_q;
    unique case (op)
      OP_RISE: begin
        if (status.rise_ok) cls_d = cls_up;
      end
      OP_FALL: begin
        if (status.fall_ok) cls_d = cls_q - 1'b1;
      end
      OP_CLAMP: begin
        // last speed follows every sample, emitted or not
        emit_d = (speed_sel != last_q) || force_q;
        last_d = speed_sel;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= MinSpeedReset;
      max_q       <= MaxSpeedReset;
      cls_q       <= TopClass;
      last_q      <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_MIN_SPEED: min_q <= cfg_wdata_i;
          CFG_MAX_SPEED: max_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      cls_q       <= cls_d;
      last_q      <= last_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sample and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      temp_q  <= temperature_i;
      force_q <= force_update_i;
    end
    if (out_load) begin
      out_speed_q <= last_q;
      out_class_q <= ClassOutW'(cls_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign speed_rpm_o   = out_speed_q;
  assign speed_word_o  = {out_speed_q, 2'b00};
  assign class_index_o = out_class_q;

  `FSHC_ASSERT(a_cls_in_range, cls_q <= TopClass, "class beyond top row")
  `FSHC_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o,
               "sequencer ready again right after taking a word")
  `FSHC_ASSERT(a_valid_from_emit, $rose(out_valid_o) |-> $past(op == OP_EMIT),
               "result appeared outside the emit step")

endmodule

// File: sv/fshc_useq.sv
// Microcode sequencer: control store, step register and conditional jumps.
// Depends on fshc_pkg.
module fshc_useq
  import fshc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  useq_status_t status_i,
  output op_e          op_o
);

  step_t  step_q, step_d;
  ucode_t uword;
  logic   cond_hit;

  // control store
  always_comb begin
    unique case (step_q)
      STEP_WAIT:  uword = '{op: OP_WAIT,  cond: COND_NO_INPUT,    jmp: STEP_WAIT,
                            nxt: STEP_RISE};
      STEP_RISE:  uword = '{op: OP_RISE,  cond: COND_RISE_OK,     jmp: STEP_RISE,
                            nxt: STEP_FALL};
      STEP_FALL:  uword = '{op: OP_FALL,  cond: COND_FALL_OK,     jmp: STEP_FALL,
                            nxt: STEP_CLAMP};
      STEP_CLAMP: uword = '{op: OP_CLAMP, cond: COND_NEVER,       jmp: STEP_WAIT,
                            nxt: STEP_EMIT};
      STEP_EMIT:  uword = '{op: OP_EMIT,  cond: COND_OUT_BLOCKED, jmp: STEP_EMIT,
                            nxt: STEP_WAIT};
      default:    uword = '{op: OP_WAIT,  cond: COND_NEVER,       jmp: STEP_WAIT,
                            nxt: STEP_WAIT};
    endcase
  end

  always_comb begin
    unique case (uword.cond)
      COND_NO_INPUT:    cond_hit = !status_i.in_accept;
      COND_RISE_OK:     cond_hit = status_i.rise_ok;
      COND_FALL_OK:     cond_hit = status_i.fall_ok;
      COND_OUT_BLOCKED: cond_hit = status_i.out_blocked;
      default:          cond_hit = 1'b0;
    endcase
    step_d = cond_hit ? uword.jmp : uword.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign op_o = uword.op;

endmodule
